// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the clustering block's modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MSKC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MSKC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mskc_pkg.sv -----
// Shared constants, codes and controller/datapath types of the clustering block.
// No dependencies.
package mskc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 65536;
  localparam int WEIGHT_BITS  = 24;

  localparam int VERT_W  = $clog2(MAX_VERTICES);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int CNT_W   = EDGE_AW + 1;
  localparam int CFG_W   = 11;
  localparam int ROOTS_W = CFG_W;
  localparam int RANK_W  = $clog2(VERT_W + 1);
  localparam int ENTRY_W = WEIGHT_BITS + 2 * VERT_W;
  localparam int PADDR_W = 3;

  localparam logic REG_VERTEX_COUNT   = 1'b0;
  localparam logic REG_CLUSTER_TARGET = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_RESULT,
    OP_INIT_START,
    OP_INIT_WR,
    OP_BUILD_START,
    OP_BUILD_NEXT,
    OP_LOAD_ROOTVAL,
    OP_SIFT_C,
    OP_SIFT_C1,
    OP_SIFT_CMP2,
    OP_SIFT_STEP,
    OP_SIFT_END,
    OP_SORT_START,
    OP_SORT_RD0,
    OP_SORT_RDE,
    OP_SORT_SWAP,
    OP_SORT_NEXT,
    OP_KR_START,
    OP_KR_RD,
    OP_KR_LD,
    OP_FIND_RD,
    OP_FIND_STEP,
    OP_FIND_A,
    OP_FIND_B,
    OP_JOIN_RA,
    OP_JOIN_RB,
    OP_JOIN_WR,
    OP_NEXT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] err_code;
    logic       cnt_lt2;
    logic       c_ge_lim;
    logic       c1_lt_lim;
    logic       root_ge;
    logic       i_zero;
    logic       init_done;
    logic       kr_exh;
    logic       roots_eq;
    logic       par_is_x;
    logic       roots_diff;
    logic       out_busy;
  } stat_t;

endpackage

// ----- hdl/mskc_if.sv -----
// Handshake interfaces for the edge input channel and the result channel.
// Depends on mskc_pkg.
interface mskc_edge_if;
  import mskc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VERT_W-1:0]      first_vertex;
  logic [VERT_W-1:0]      second_vertex;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic                   last_edge;
  modport source (output valid, first_vertex, second_vertex, edge_weight, last_edge,
                  input ready);
  modport sink (input valid, first_vertex, second_vertex, edge_weight, last_edge,
                output ready);
endinterface

interface mskc_result_if;
  import mskc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] max_spacing;
  logic [1:0]             status;
  modport source (output valid, max_spacing, status, input ready);
  modport sink (input valid, max_spacing, status, output ready);
endinterface

// ----- hdl/mskc_datapath.sv -----
// Datapath: edge store, union-find stores, sort and merge registers, result register.
// Depends on mskc_pkg and assert_macros.svh; driven by mskc_controller commands.
`include "assert_macros.svh"
module mskc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mskc_pkg::cmd_t                   cmd,
  output mskc_pkg::stat_t                  stat,
  input  logic [mskc_pkg::CFG_W-1:0]       vertex_count,
  input  logic [mskc_pkg::CFG_W-1:0]       cluster_target,
  input  logic [mskc_pkg::VERT_W-1:0]      in_first_vertex,
  input  logic [mskc_pkg::VERT_W-1:0]      in_second_vertex,
  input  logic [mskc_pkg::WEIGHT_BITS-1:0] in_edge_weight,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mskc_pkg::WEIGHT_BITS-1:0] out_max_spacing,
  output logic [1:0]                       out_status
);
  import mskc_pkg::*;

  logic [ENTRY_W-1:0] edge_mem [MAX_EDGES];
  logic [VERT_W-1:0]  par_mem  [MAX_VERTICES];
  logic [RANK_W-1:0]  rank_mem [MAX_VERTICES];

  logic [ENTRY_W-1:0] ed_q;
  logic [VERT_W-1:0]  par_q;
  logic [RANK_W-1:0]  rank_q;

  logic               e_we;
  logic [EDGE_AW-1:0] e_waddr, e_raddr;
  logic [ENTRY_W-1:0] e_wdata;
  logic               p_we;
  logic [VERT_W-1:0]  p_waddr, p_raddr, p_wdata;
  logic               r_we;
  logic [VERT_W-1:0]  r_waddr, r_raddr;
  logic [RANK_W-1:0]  r_wdata;

  logic [CNT_W-1:0]       edge_cnt_r, i_r, c_r, lim_r;
  logic [1:0]             err_r;
  logic [EDGE_AW-1:0]     root_r;
  logic [ENTRY_W-1:0]     rootval_r, cval_r;
  logic [ROOTS_W-1:0]     roots_r;
  logic [VERT_W-1:0]      eb_r, x_r, ra_r, rb_r;
  logic [WEIGHT_BITS-1:0] w_r, spacing_r;
  logic [RANK_W-1:0]      rka_r;
  logic                   out_valid_r;
  logic [1:0]             status_r;

  logic [CFG_W-1:0] v_eff;
  logic [CNT_W-1:0] c_first, c1, i_m1;
  logic             in_range;

  assign v_eff    = (vertex_count > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vertex_count;
  assign c_first  = {root_r, 1'b1};
  assign c1       = c_r + CNT_W'(1);
  assign i_m1     = i_r - CNT_W'(1);
  assign in_range = (CFG_W'(in_first_vertex) < v_eff) && (CFG_W'(in_second_vertex) < v_eff);

  assign stat.err_code   = err_r;
  assign stat.cnt_lt2    = edge_cnt_r < CNT_W'(2);
  assign stat.c_ge_lim   = c_first >= lim_r;
  assign stat.c1_lt_lim  = c1 < lim_r;
  assign stat.root_ge    = rootval_r >= cval_r;
  assign stat.i_zero     = i_r == '0;
  assign stat.init_done  = i_r >= CNT_W'(v_eff);
  assign stat.kr_exh     = i_r >= edge_cnt_r;
  assign stat.roots_eq   = roots_r == cluster_target;
  assign stat.par_is_x   = par_q == x_r;
  assign stat.roots_diff = ra_r != rb_r;
  assign stat.out_busy   = out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_max_spacing = spacing_r;
  assign out_status      = status_r;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = root_r;
    e_wdata = rootval_r;
    e_raddr = i_r[EDGE_AW-1:0];
    p_we    = 1'b0;
    p_waddr = i_r[VERT_W-1:0];
    p_wdata = i_r[VERT_W-1:0];
    p_raddr = x_r;
    r_we    = 1'b0;
    r_waddr = i_r[VERT_W-1:0];
    r_wdata = '0;
    r_raddr = ra_r;
    unique case (cmd.op)
      OP_STORE: begin
        if (in_range && err_r == ST_OK && edge_cnt_r < CNT_W'(MAX_EDGES)) begin
          e_we    = 1'b1;
          e_waddr = edge_cnt_r[EDGE_AW-1:0];
          e_wdata = {in_edge_weight, in_first_vertex, in_second_vertex};
        end else if (in_range && edge_cnt_r < CNT_W'(MAX_EDGES)) begin
          e_we    = 1'b1;
          e_waddr = edge_cnt_r[EDGE_AW-1:0];
          e_wdata = {in_edge_weight, in_first_vertex, in_second_vertex};
        end
      end
      OP_INIT_WR: begin
        p_we = 1'b1;
        r_we = 1'b1;
      end
      OP_BUILD_NEXT: e_raddr = i_m1[EDGE_AW-1:0];
      OP_SIFT_C:     e_raddr = c_first[EDGE_AW-1:0];
      OP_SIFT_C1:    e_raddr = c1[EDGE_AW-1:0];
      OP_SIFT_STEP: begin
        e_we    = 1'b1;
        e_wdata = cval_r;
      end
      OP_SIFT_END:   e_we = 1'b1;
      OP_SORT_RD0:   e_raddr = '0;
      OP_SORT_SWAP: begin
        e_we    = 1'b1;
        e_waddr = i_r[EDGE_AW-1:0];
        e_wdata = cval_r;
      end
      OP_FIND_STEP:  p_raddr = par_q;
      OP_JOIN_RB:    r_raddr = rb_r;
      OP_JOIN_WR: begin
        p_we = 1'b1;
        if (rka_r > rank_q) begin
          p_waddr = rb_r;
          p_wdata = ra_r;
        end else if (rank_q > rka_r) begin
          p_waddr = ra_r;
          p_wdata = rb_r;
        end else begin
          p_waddr = rb_r;
          p_wdata = ra_r;
          r_we    = 1'b1;
          r_waddr = ra_r;
          r_wdata = rka_r + RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    ed_q <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      par_mem[p_waddr] <= p_wdata;
    end
    par_q <= par_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    rank_q <= rank_mem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r  <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_STORE: begin
          if (!in_range) begin
            if (err_r == ST_OK) begin
              err_r <= ST_RANGE;
            end
          end else if (edge_cnt_r >= CNT_W'(MAX_EDGES)) begin
            if (err_r == ST_OK) begin
              err_r <= ST_OVERFLOW;
            end
          end else begin
            edge_cnt_r <= edge_cnt_r + CNT_W'(1);
          end
        end
        OP_RESULT: begin
          out_valid_r <= 1'b1;
          status_r    <= cmd.res_status;
          spacing_r   <= (cmd.res_status == ST_OK) ? w_r : '0;
          edge_cnt_r  <= '0;
          err_r       <= ST_OK;
        end
        OP_INIT_START:   i_r <= '0;
        OP_INIT_WR:      i_r <= i_r + CNT_W'(1);
        OP_BUILD_START:  i_r <= edge_cnt_r >> 1;
        OP_BUILD_NEXT: begin
          i_r    <= i_m1;
          root_r <= i_m1[EDGE_AW-1:0];
          lim_r  <= edge_cnt_r;
        end
        OP_LOAD_ROOTVAL: rootval_r <= ed_q;
        OP_SIFT_C:       c_r <= c_first;
        OP_SIFT_C1:      cval_r <= ed_q;
        OP_SIFT_CMP2: begin
          if (ed_q > cval_r) begin
            c_r    <= c1;
            cval_r <= ed_q;
          end
        end
        OP_SIFT_STEP:    root_r <= c_r[EDGE_AW-1:0];
        OP_SORT_START:   i_r <= edge_cnt_r - CNT_W'(1);
        OP_SORT_RDE:     cval_r <= ed_q;
        OP_SORT_SWAP: begin
          rootval_r <= ed_q;
          root_r    <= '0;
          lim_r     <= i_r;
        end
        OP_SORT_NEXT:    i_r <= i_m1;
        OP_KR_START: begin
          i_r     <= '0;
          roots_r <= v_eff;
        end
        OP_KR_LD: begin
          eb_r <= ed_q[VERT_W-1:0];
          x_r  <= ed_q[2*VERT_W-1:VERT_W];
          w_r  <= ed_q[ENTRY_W-1 -: WEIGHT_BITS];
        end
        OP_FIND_STEP:    x_r <= par_q;
        OP_FIND_A: begin
          ra_r <= x_r;
          x_r  <= eb_r;
        end
        OP_FIND_B:       rb_r <= x_r;
        OP_JOIN_RB:      rka_r <= rank_q;
        OP_JOIN_WR: begin
          roots_r <= roots_r - ROOTS_W'(1);
          i_r     <= i_r + CNT_W'(1);
        end
        OP_NEXT:         i_r <= i_r + CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  `MSKC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, edge_cnt_r <= CNT_W'(MAX_EDGES), "edge count past store depth")
  `MSKC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && status_r != ST_OK, spacing_r == '0, "nonzero spacing with error status")
  `MSKC_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.op == OP_RESULT, !out_valid_r, "result register overwritten")

endmodule

// ----- hdl/mskc_controller.sv -----
// Controller state machine: edge loading, heapsort, union-find merging and scan.
// Depends on mskc_pkg and assert_macros.svh; commands mskc_datapath.
`include "assert_macros.svh"
module mskc_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  mskc_pkg::stat_t stat,
  output mskc_pkg::cmd_t  cmd
);
  import mskc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_INIT, S_BUILD_CHK, S_LOADR, S_SIFT_C, S_SIFT_C1, S_SIFT_CMP2,
    S_SIFT_CMP, S_SIFT_END, S_SORT_CHK, S_SORT_RDE, S_SORT_SWAP, S_SORT_DEC, S_KR_CHK,
    S_KR_LD, S_FIND_RD, S_FIND_CHK, S_K_DEC, S_JOIN_RB, S_JOIN_WR, S_RES
  } state_t;

  state_t     state_r, state_nxt;
  logic       sorting_r, sorting_nxt;
  logic       scan_r, scan_nxt;
  logic       fb_r, fb_nxt;
  logic [1:0] res_r, res_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    sorting_nxt    = sorting_r;
    scan_nxt       = scan_r;
    fb_nxt         = fb_r;
    res_nxt        = res_r;
    cmd.op         = OP_NONE;
    cmd.res_status = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_STORE;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.err_code != ST_OK) begin
          res_nxt   = stat.err_code;
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_INIT_START;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.init_done) begin
          cmd.op      = OP_BUILD_START;
          sorting_nxt = 1'b0;
          state_nxt   = S_BUILD_CHK;
        end else begin
          cmd.op = OP_INIT_WR;
        end
      end
      S_BUILD_CHK: begin
        if (!stat.i_zero) begin
          cmd.op    = OP_BUILD_NEXT;
          state_nxt = S_LOADR;
        end else if (stat.cnt_lt2) begin
          cmd.op    = OP_KR_START;
          scan_nxt  = 1'b0;
          state_nxt = S_KR_CHK;
        end else begin
          cmd.op      = OP_SORT_START;
          sorting_nxt = 1'b1;
          state_nxt   = S_SORT_CHK;
        end
      end
      S_LOADR: begin
        cmd.op    = OP_LOAD_ROOTVAL;
        state_nxt = S_SIFT_C;
      end
      S_SIFT_C: begin
        if (stat.c_ge_lim) begin
          state_nxt = S_SIFT_END;
        end else begin
          cmd.op    = OP_SIFT_C;
          state_nxt = S_SIFT_C1;
        end
      end
      S_SIFT_C1: begin
        cmd.op    = OP_SIFT_C1;
        state_nxt = stat.c1_lt_lim ? S_SIFT_CMP2 : S_SIFT_CMP;
      end
      S_SIFT_CMP2: begin
        cmd.op    = OP_SIFT_CMP2;
        state_nxt = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        if (stat.root_ge) begin
          state_nxt = S_SIFT_END;
        end else begin
          cmd.op    = OP_SIFT_STEP;
          state_nxt = S_SIFT_C;
        end
      end
      S_SIFT_END: begin
        cmd.op    = OP_SIFT_END;
        state_nxt = sorting_r ? S_SORT_DEC : S_BUILD_CHK;
      end
      S_SORT_CHK: begin
        if (stat.i_zero) begin
          cmd.op    = OP_KR_START;
          scan_nxt  = 1'b0;
          state_nxt = S_KR_CHK;
        end else begin
          cmd.op    = OP_SORT_RD0;
          state_nxt = S_SORT_RDE;
        end
      end
      S_SORT_RDE: begin
        cmd.op    = OP_SORT_RDE;
        state_nxt = S_SORT_SWAP;
      end
      S_SORT_SWAP: begin
        cmd.op    = OP_SORT_SWAP;
        state_nxt = S_SIFT_C;
      end
      S_SORT_DEC: begin
        cmd.op    = OP_SORT_NEXT;
        state_nxt = S_SORT_CHK;
      end
      S_KR_CHK: begin
        if (!scan_r && stat.roots_eq) begin
          scan_nxt = 1'b1;
        end else if (stat.kr_exh) begin
          res_nxt   = ST_EXHAUSTED;
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_KR_RD;
          state_nxt = S_KR_LD;
        end
      end
      S_KR_LD: begin
        cmd.op    = OP_KR_LD;
        fb_nxt    = 1'b0;
        state_nxt = S_FIND_RD;
      end
      S_FIND_RD: begin
        cmd.op    = OP_FIND_RD;
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (!stat.par_is_x) begin
          cmd.op = OP_FIND_STEP;
        end else if (!fb_r) begin
          cmd.op    = OP_FIND_A;
          fb_nxt    = 1'b1;
          state_nxt = S_FIND_RD;
        end else begin
          cmd.op    = OP_FIND_B;
          state_nxt = S_K_DEC;
        end
      end
      S_K_DEC: begin
        if (!stat.roots_diff) begin
          cmd.op    = OP_NEXT;
          state_nxt = S_KR_CHK;
        end else if (scan_r) begin
          res_nxt   = ST_OK;
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_JOIN_RA;
          state_nxt = S_JOIN_RB;
        end
      end
      S_JOIN_RB: begin
        cmd.op    = OP_JOIN_RB;
        state_nxt = S_JOIN_WR;
      end
      S_JOIN_WR: begin
        cmd.op    = OP_JOIN_WR;
        state_nxt = S_KR_CHK;
      end
      S_RES: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sorting_r <= 1'b0;
      scan_r    <= 1'b0;
      fb_r      <= 1'b0;
      res_r     <= ST_OK;
    end else begin
      state_r   <= state_nxt;
      sorting_r <= sorting_nxt;
      scan_r    <= scan_nxt;
      fb_r      <= fb_nxt;
      res_r     <= res_nxt;
    end
  end

  `MSKC_ASSERT_IMP(a_store_idle, clk, rst_n, cmd.op == OP_STORE, state_r == S_IDLE, "edge stored outside idle")
  `MSKC_ASSERT_NEXT(a_result_idle, clk, rst_n, cmd.op == OP_RESULT, state_r == S_IDLE, "no return to idle after result")
  `MSKC_ASSERT_IMP(a_join_merge, clk, rst_n, cmd.op == OP_JOIN_RA, !scan_r, "merge issued during scan")

endmodule

// ----- hdl/max_spacing_k_clustering.sv -----
// Channel    | Dir | Handshake              | Payload
// in_edge    | in  | valid/ready            | first_vertex, second_vertex, edge_weight, last_edge
// out_result | out | valid/ready            | max_spacing, status
// cfg (APB)  | in  | psel/penable/pready    | paddr, pwdata, prdata
// An edge without last_edge is taken while the block is idle; the edge with last_edge starts a run.
// A run sets up a forest of single-vertex sets, heapsorts the stored edges by weight, then
// finds both endpoint roots of each edge in order, merging differing roots until the cluster
// target is reached, then scanning for the next edge that joins two clusters.
// Input stalls for the whole run.
// The result waits in an output register; reset is synchronous and clears control state.
// Top level: configuration registers, controller and datapath.
// Depends on mskc_pkg, mskc_if, mskc_controller and mskc_datapath.
module max_spacing_k_clustering (
  input  logic                         clk,
  input  logic                         rst_n,
  mskc_edge_if.sink                    in_edge,
  mskc_result_if.source                out_result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mskc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mskc_pkg::*;

  logic [CFG_W-1:0] vertex_count_r, cluster_target_r;
  cmd_t             cmd;
  stat_t            stat;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1];
  assign prdata  = (reg_sel == REG_CLUSTER_TARGET) ? 32'(cluster_target_r)
                                                   : 32'(vertex_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r   <= CFG_W'(1024);
      cluster_target_r <= CFG_W'(4);
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_VERTEX_COUNT) begin
        vertex_count_r <= pwdata[CFG_W-1:0];
      end else begin
        cluster_target_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  mskc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_edge.valid),
    .in_last  (in_edge.last_edge),
    .in_ready (in_edge.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mskc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .vertex_count     (vertex_count_r),
    .cluster_target   (cluster_target_r),
    .in_first_vertex  (in_edge.first_vertex),
    .in_second_vertex (in_edge.second_vertex),
    .in_edge_weight   (in_edge.edge_weight),
    .out_valid        (out_result.valid),
    .out_ready        (out_result.ready),
    .out_max_spacing  (out_result.max_spacing),
    .out_status       (out_result.status)
  );

endmodule
